FILE: src/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and byte codes for the Turkish letter filter.
// ----------------------------------------------------------------------------
package tlf_pkg;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic [15:0] CAPACITY_RST = 16'd4096;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// byte codes
	localparam logic [7:0] LEAD_C3     = 8'hC3;
	localparam logic [7:0] LEAD_C4     = 8'hC4;
	localparam logic [7:0] LEAD_C5     = 8'hC5;
	localparam logic [7:0] CONT_A7     = 8'hA7;
	localparam logic [7:0] CONT_B6     = 8'hB6;
	localparam logic [7:0] CONT_BC     = 8'hBC;
	localparam logic [7:0] CONT_9F     = 8'h9F;
	localparam logic [7:0] CONT_B1     = 8'hB1;
	localparam logic [7:0] CONT_B0     = 8'hB0;
	localparam logic [7:0] MASK_E0     = 8'hE0;
	localparam logic [7:0] MASK_F0     = 8'hF0;
	localparam logic [7:0] MASK_F8     = 8'hF8;
	localparam logic [7:0] PFX_TWO     = 8'hC0;
	localparam logic [7:0] PFX_THREE   = 8'hE0;
	localparam logic [7:0] PFX_FOUR    = 8'hF0;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHR_LOWER_I = 8'h69;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [7:0] CHR_NUL     = 8'h00;

	typedef struct packed {
		logic [1:0]  bytes_remaining;
		logic        in_two_byte_char;
		logic [7:0]  held_lead_byte;
		logic [15:0] emitted_count;
	} state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_text;
	} result_t;

	// what one text byte produces: zero, one or two words
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} dec_out_t;

endpackage

FILE: src/tlf_decode.sv
// ----------------------------------------------------------------------------
// tlf_decode
// Per-byte decode: next filter state and the words one text byte produces.
// ----------------------------------------------------------------------------
module tlf_decode (
	input  logic [7:0]           in_byte,
	input  tlf_pkg::state_t      st,
	input  logic [15:0]          capacity,
	output tlf_pkg::state_t      st_next,
	output tlf_pkg::dec_out_t    dout
);

	logic [16:0] limit;
	logic        fits1;
	logic        fits2;
	logic        keep2;

	assign limit = {1'b0, capacity};
	assign fits1 = ({1'b0, st.emitted_count} + 17'd2) < limit;
	assign fits2 = ({1'b0, st.emitted_count} + 17'd3) < limit;

	// turkish lowercase pairs passed through unchanged
	assign keep2 = ((st.held_lead_byte == tlf_pkg::LEAD_C3) &&
			(in_byte == tlf_pkg::CONT_A7 || in_byte == tlf_pkg::CONT_B6 ||
			 in_byte == tlf_pkg::CONT_BC)) ||
		((st.held_lead_byte == tlf_pkg::LEAD_C4) &&
			(in_byte == tlf_pkg::CONT_9F || in_byte == tlf_pkg::CONT_B1)) ||
		((st.held_lead_byte == tlf_pkg::LEAD_C5) && (in_byte == tlf_pkg::CONT_9F));

	always_comb begin
		st_next = st;
		dout = '0;
		if (in_byte == tlf_pkg::CHR_NUL) begin
			// end of text, also inside a partial character
			st_next = '0;
			dout.count = 2'd1;
			dout.r0 = '{out_byte: tlf_pkg::CHR_NUL, last_of_run: 1'b1, end_of_text: 1'b1};
		end else if (st.bytes_remaining != 2'd0) begin
			if (st.in_two_byte_char) begin
				st_next.bytes_remaining = 2'd0;
				st_next.in_two_byte_char = 1'b0;
				st_next.held_lead_byte = '0;
				if (st.held_lead_byte == tlf_pkg::LEAD_C4 && in_byte == tlf_pkg::CONT_B0) begin
					// capital dotted i becomes plain i
					if (fits1) begin
						dout.count = 2'd1;
						dout.r0 = '{out_byte: tlf_pkg::CHR_LOWER_I, last_of_run: 1'b1,
							end_of_text: 1'b0};
						st_next.emitted_count = st.emitted_count + 16'd1;
					end
				end else if (keep2 && fits2) begin
					dout.count = 2'd2;
					dout.r0 = '{out_byte: st.held_lead_byte, last_of_run: 1'b0,
						end_of_text: 1'b0};
					dout.r1 = '{out_byte: in_byte, last_of_run: 1'b1, end_of_text: 1'b0};
					st_next.emitted_count = st.emitted_count + 16'd2;
				end
			end else begin
				st_next.bytes_remaining = st.bytes_remaining - 2'd1;
			end
		end else if (!in_byte[7]) begin
			if (in_byte >= tlf_pkg::CHR_UPPER_A && in_byte <= tlf_pkg::CHR_UPPER_Z) begin
				if (fits1) begin
					dout.count = 2'd1;
					dout.r0 = '{out_byte: in_byte + tlf_pkg::CASE_OFFSET, last_of_run: 1'b1,
						end_of_text: 1'b0};
					st_next.emitted_count = st.emitted_count + 16'd1;
				end
			end else if (in_byte >= tlf_pkg::CHR_LOWER_A &&
					in_byte <= tlf_pkg::CHR_LOWER_Z) begin
				if (fits1) begin
					dout.count = 2'd1;
					dout.r0 = '{out_byte: in_byte, last_of_run: 1'b1, end_of_text: 1'b0};
					st_next.emitted_count = st.emitted_count + 16'd1;
				end
			end
		end else if ((in_byte & tlf_pkg::MASK_E0) == tlf_pkg::PFX_TWO) begin
			st_next.held_lead_byte = in_byte;
			st_next.in_two_byte_char = 1'b1;
			st_next.bytes_remaining = 2'd1;
		end else if ((in_byte & tlf_pkg::MASK_F0) == tlf_pkg::PFX_THREE) begin
			st_next.bytes_remaining = 2'd2;
		end else if ((in_byte & tlf_pkg::MASK_F8) == tlf_pkg::PFX_FOUR) begin
			st_next.bytes_remaining = 2'd3;
		end
	end

endmodule

FILE: src/tlf_outq.sv
// ----------------------------------------------------------------------------
// tlf_outq
// Small result queue: takes up to two words a cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module tlf_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tlf_pkg::dec_out_t          push,
	output logic                       room2,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tlf_pkg::result_t           out_word
);

	tlf_pkg::result_t                  mem_q [tlf_pkg::QUEUE_DEPTH];
	logic [tlf_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [tlf_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [tlf_pkg::QCNT_W-1:0]        cnt_q;
	logic                              pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_word  = mem_q[rd_ptr_q];
	assign room2     = (cnt_q <= tlf_pkg::QCNT_W'(tlf_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.count == 2'd2)
			mem_q[wr_ptr_q + tlf_pkg::QPTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tlf_pkg::QPTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + tlf_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + tlf_pkg::QCNT_W'(push.count) - tlf_pkg::QCNT_W'(pop);
		end
	end

endmodule

FILE: src/utf8_turkish_letter_filter_lowercase.sv
// ----------------------------------------------------------------------------
// utf8_turkish_letter_filter_lowercase
// Keeps ascii and turkish lowercase letters of a utf-8 byte stream.
// ----------------------------------------------------------------------------
// order: a text byte is registered in the input stage, decoded from there
//   and its words written into the result queue, which offers them in turn
// throughput: one text byte per cycle while the four-word result queue holds
//   two words or fewer; a byte that yields two words fills the queue faster
//   than it hands words out, so such bytes back to back stall the input
// reset: filter state, input stage and queue clear; capacity reads 4096
module utf8_turkish_letter_filter_lowercase (
	input  logic                         clk,
	input  logic                         arst_n,
	// text byte channel
	input  logic [7:0]                   in_byte,
	input  logic                         in_valid,
	output logic                         in_stall,
	// result channel
	output logic [7:0]                   out_byte,
	output logic                         last_of_run,
	output logic                         end_of_text,
	output logic                         out_valid,
	input  logic                         out_stall,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tlf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [7:0]          byte_s1;
	logic                valid_s1;
	logic                in_accept;
	logic                process;
	logic                room2;
	logic [15:0]         capacity_q;
	tlf_pkg::state_t     st_q;
	tlf_pkg::state_t     st_next;
	tlf_pkg::dec_out_t   dec;
	tlf_pkg::dec_out_t   push;
	tlf_pkg::result_t    out_word;

	// ------------------------------------------------------------------
	// register port: capacity at addresses 0 to 3 (paddr[2] low), others read zero
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= tlf_pkg::CAPACITY_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// input stage: holds one byte until the queue has room for two words
	// ------------------------------------------------------------------
	assign process   = valid_s1 && room2;
	assign in_stall  = valid_s1 && !process;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept)
			byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !process);
		end
	end

	// ------------------------------------------------------------------
	// decode and filter state
	// ------------------------------------------------------------------
	tlf_decode u_decode (
		.in_byte     (byte_s1),
		.st          (st_q),
		.capacity    (capacity_q),
		.st_next     (st_next),
		.dout        (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (process) begin
			st_q <= st_next;
		end
	end

	// only a decoded byte pushes words
	always_comb begin
		push = dec;
		if (!process)
			push.count = 2'd0;
	end

	// ------------------------------------------------------------------
	// result queue
	// ------------------------------------------------------------------
	tlf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign out_byte    = out_word.out_byte;
	assign last_of_run = out_word.last_of_run;
	assign end_of_text = out_word.end_of_text;

endmodule

FILE: tb/sv/tlf_filter_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlf_filter_check_pkg
// Scoreboard for the Turkish letter filter: predicts the cleaned words of
// each accepted text byte and checks the words leaving the block in order.
// ----------------------------------------------------------------------------
package tlf_filter_check_pkg;

	import tlf_pkg::*;

	localparam logic [7:0] ASCII_END = 8'h80;

	class letter_filter_checker;

		logic [15:0] capacity;
		logic [1:0]  cont_left;
		bit          two_byte;
		logic [7:0]  lead;
		logic [15:0] emitted;
		result_t     expected_words[$];
		int unsigned errors;
		int unsigned words_checked;
		int unsigned bytes_taken;

		function new();
			capacity = CAPACITY_RST;
			errors = 0;
			words_checked = 0;
			bytes_taken = 0;
			clear_text();
		endfunction

		function void clear_text();
			cont_left = 2'd0;
			two_byte = 1'b0;
			lead = 8'h00;
			emitted = 16'h0000;
		endfunction

		function void set_capacity(logic [15:0] value);
			capacity = value;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		// a character is kept whole only if it and the terminator still fit
		function void emit_char(logic [7:0] b0, logic [7:0] b1, int len);
			result_t w;
			if (int'(emitted) + len + 1 >= int'(capacity))
				return;
			w.out_byte = b0;
			w.last_of_run = (len == 1);
			w.end_of_text = 1'b0;
			expected_words.push_back(w);
			if (len == 2) begin
				w.out_byte = b1;
				w.last_of_run = 1'b1;
				expected_words.push_back(w);
			end
			emitted = emitted + 16'(len);
		endfunction

		// note one accepted text byte and queue the words it yields
		function void take_byte(logic [7:0] c);
			result_t    term;
			logic [7:0] l;
			bytes_taken++;
			if (c == CHR_NUL) begin
				term.out_byte = CHR_NUL;
				term.last_of_run = 1'b1;
				term.end_of_text = 1'b1;
				expected_words.push_back(term);
				clear_text();
			end else if (cont_left != 2'd0) begin
				if (two_byte) begin
					l = lead;
					cont_left = 2'd0;
					two_byte = 1'b0;
					lead = 8'h00;
					if (l == LEAD_C4 && c == CONT_B0)
						emit_char(CHR_LOWER_I, CHR_NUL, 1);
					else if ((l == LEAD_C3 && (c == CONT_A7 || c == CONT_B6 || c == CONT_BC)) ||
							(l == LEAD_C4 && (c == CONT_9F || c == CONT_B1)) ||
							(l == LEAD_C5 && c == CONT_9F))
						emit_char(l, c, 2);
				end else
					cont_left = cont_left - 2'd1;
			end else if (c < ASCII_END) begin
				if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z)
					emit_char(c + CASE_OFFSET, CHR_NUL, 1);
				else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
					emit_char(c, CHR_NUL, 1);
			end else if ((c & MASK_E0) == PFX_TWO) begin
				lead = c;
				two_byte = 1'b1;
				cont_left = 2'd1;
			end else if ((c & MASK_F0) == PFX_THREE)
				cont_left = 2'd2;
			else if ((c & MASK_F8) == PFX_FOUR)
				cont_left = 2'd3;
		endfunction

		// compare one accepted word with the oldest expectation
		function void check_word(result_t got);
			result_t want;
			words_checked++;
			if (expected_words.size() == 0) begin
				$error("unexpected word: out_byte %02h last_of_run %0b end_of_text %0b",
					got.out_byte, got.last_of_run, got.end_of_text);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
				errors++;
			end
			if (got.end_of_text !== want.end_of_text) begin
				$error("end_of_text: expected %0b, got %0b", want.end_of_text, got.end_of_text);
				errors++;
			end
		endfunction

	endclass

endpackage

FILE: tb/sv/tb_utf8_turkish_letter_filter_lowercase.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_turkish_letter_filter_lowercase
// Feeds utf-8 texts through the letter filter under several capacity
// settings, with random gaps and stalls on both channels, and checks every
// word against a scoreboard that predicts the cleaned, lowercased text.
// ----------------------------------------------------------------------------
module tb_utf8_turkish_letter_filter_lowercase;

	import tlf_pkg::*;
	import tlf_filter_check_pkg::*;

	// register map: capacity is register 0
	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = '0;
	localparam int NUM_PHASES      = 10;
	localparam int PHASE_BYTES     = 100;
	localparam int DRAIN_CYCLES    = 8;    // well past the input stage and the queue
	localparam int PRESSURE_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic [7:0]  in_byte;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	letter_filter_checker sb;

	// idling control shared by the sender and the receiver
	bit idle_enable = 1'b0;
	bit pressure_req = 1'b0;
	int stall_left = 0;
	int hold_left = 0;

	int unsigned texts_ended = 0;
	int unsigned settings_used = 0;
	logic [7:0] text_q[$];

	// short directed text: letter extremes, three turkish cases, skipped
	// multibyte chars, stray and invalid leads, zero inside a sequence,
	// then an empty text
	logic [7:0] directed_text [0:24] = '{
		8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B,
		LEAD_C3, CONT_A7, LEAD_C4, CONT_B0, LEAD_C5, CONT_9F,
		8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
		8'h80, 8'hF8, 8'hFF, LEAD_C3, CHR_NUL, CHR_NUL
	};

	utf8_turkish_letter_filter_lowercase dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("tb_utf8_turkish_letter_filter_lowercase failed");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request so
	// the result queue fills and the block stalls its text input
	always @(negedge clk) begin
		if (pressure_req) begin
			pressure_req = 1'b0;
			hold_left = PRESSURE_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word('{out_byte, last_of_run, end_of_text});
	end

	// offer one text byte, with an optional gap first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (idle_enable && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
		if (b == CHR_NUL)
			texts_ended++;
	endtask

	task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_CAPACITY;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_capacity(input logic [15:0] want);
		logic [31:0] rd;
		apb_cycle(1'b0, 32'h0, rd);
		if (rd[15:0] !== want) begin
			$error("capacity: expected %0d, got %0d", want, rd[15:0]);
			sb.errors++;
		end
	endtask

	task automatic set_capacity(input logic [15:0] value);
		logic [31:0] rd;
		apb_cycle(1'b1, {16'h0, value}, rd);
		sb.set_capacity(value);
		settings_used++;
		check_capacity(value);
	endtask

	// block is idle once every expected word is out and the pipe is drained
	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] turkish_letter(int k);
		case (k)
			0: return {LEAD_C3, CONT_A7};
			1: return {LEAD_C3, CONT_B6};
			2: return {LEAD_C3, CONT_BC};
			3: return {LEAD_C4, CONT_9F};
			4: return {LEAD_C4, CONT_B1};
			default: return {LEAD_C5, CONT_9F};
		endcase
	endfunction

	// build one random text in text_q: mostly well-formed characters with
	// random content, some noise and broken sequences, always zero-ended
	task automatic build_text();
		int n_chars;
		int pick;
		int n_cont;
		logic [15:0] pair;
		bit ended;
		text_q.delete();
		ended = 1'b0;
		n_chars = $urandom_range(2, 25);
		for (int i = 0; i < n_chars && !ended; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				text_q.push_back(8'($urandom_range(CHR_UPPER_A, CHR_UPPER_Z)));
			else if (pick < 30)
				text_q.push_back(8'($urandom_range(CHR_LOWER_A, CHR_LOWER_Z)));
			else if (pick < 40)
				// any ascii, letters or not
				text_q.push_back(8'($urandom_range(1, 127)));
			else if (pick < 60) begin
				pair = turkish_letter($urandom_range(0, 5));
				text_q.push_back(pair[15:8]);
				text_q.push_back(pair[7:0]);
			end else if (pick < 65) begin
				// capital dotted i
				text_q.push_back(LEAD_C4);
				text_q.push_back(CONT_B0);
			end else if (pick < 73) begin
				text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
				text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 80) begin
				text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
				repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 86) begin
				text_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
				repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end else if (pick < 89)
				// stray continuation byte in lead position
				text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			else if (pick < 92)
				text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			else if (pick < 97) begin
				// truncated sequence, the next character gets swallowed
				text_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
				n_cont = $urandom_range(0, 2);
				repeat (n_cont) text_q.push_back(8'($urandom_range(1, 255)));
			end else begin
				// zero inside a multibyte character ends the text
				text_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
				n_cont = $urandom_range(0, 2);
				repeat (n_cont) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
				text_q.push_back(CHR_NUL);
				ended = 1'b1;
			end
		end
		if (!ended)
			text_q.push_back(CHR_NUL);
	endtask

	initial begin
		int unsigned phase_bytes;
		logic [15:0] size;

		sb = new();
		arst_n = 1'b0;
		in_byte = 8'h00;
		in_valid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'h0;

		// reset held first, then released away from the clock edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_capacity(CAPACITY_RST);

		// directed text under the reset size
		idle_enable = 1'b1;
		foreach (directed_text[i])
			send_byte(directed_text[i]);
		@(negedge clk);
		in_valid <= 1'b0;
		wait_idle();

		// random phases: extremes first, then small sizes to hit the full case
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// no idling in one middle phase and in the closing phases
			idle_enable = (ph < 7) && (ph != 3);
			if (ph == 1)
				pressure_req = 1'b1;
			case (ph)
				0: size = 16'd1;
				1: size = 16'hFFFF;
				2: size = 16'd0;
				3: size = 16'd2;
				4: size = 16'd3;
				7: size = 16'($urandom_range(1, 65535));
				9: size = CAPACITY_RST;
				default: size = 16'($urandom_range(4, 30));
			endcase
			set_capacity(size);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_text();
				foreach (text_q[i])
					send_byte(text_q[i]);
				phase_bytes += text_q.size();
			end
			@(negedge clk);
			in_valid <= 1'b0;
			wait_idle();
		end

		if (sb.pending() != 0) begin
			$error("%0d expected words never arrived", sb.pending());
			sb.errors++;
		end

		$display("run covered %0d text bytes in %0d texts over %0d capacity settings",
			sb.bytes_taken, texts_ended, settings_used);
		$display("%0d result words checked, %0d mismatches", sb.words_checked, sb.errors);
		if (sb.errors == 0)
			$display("tb_utf8_turkish_letter_filter_lowercase passed");
		else
			$display("tb_utf8_turkish_letter_filter_lowercase failed");
		$finish;
	end

endmodule
